// File: src/skf_pkg.sv
// Shared constants, register codes and control structs for the scalar Kalman filter.
// No dependencies; used by every module of the block by scoped names.
package skf_pkg;

    // Field and arithmetic widths
    localparam int MEAS_W    = 16;
    localparam int EST_W     = 32;
    localparam int COV_W     = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int FRAC_W    = 16;
    localparam int GAIN_W    = FRAC_W + 1;     // holds 1.0 exactly
    localparam int DEN_W     = COV_W + 1;
    localparam int DIFF_W    = EST_W + 1;
    localparam int PROD_W    = DIFF_W + GAIN_W + 1;
    localparam int CPROD_W   = GAIN_W + COV_W;
    localparam int DIV_STEPS = GAIN_W;         // one quotient bit per step
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << FRAC_W;

    // Register reset values
    localparam logic [CFG_W-1:0] INIT_COV_RST   = 32'd65536;
    localparam logic [CFG_W-1:0] PROC_NOISE_RST = 32'd655;
    localparam logic [CFG_W-1:0] MEAS_NOISE_RST = 32'd65536;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INIT_COV   = 2'd0,
        REG_PROC_NOISE = 2'd1,
        REG_MEAS_NOISE = 2'd2
    } cfg_reg_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic prep;
        logic denom;
        logic div_start;
        logic mult;
        logic update;
        logic push;
    } skf_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic div_done;
    } skf_status_t;

endpackage

// File: src/skf_div.sv
// Iterative restoring divider for the gain: quotient = floor(dividend * 2^16 / divisor).
// One quotient bit per cycle; depends on skf_pkg.
module skf_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [skf_pkg::COV_W-1:0]           dividend,
    input  logic [skf_pkg::DEN_W-1:0]           divisor,
    output logic [skf_pkg::GAIN_W-1:0]          quotient,
    output logic                                done
);

    logic [skf_pkg::DEN_W:0]            rem_reg;
    logic [skf_pkg::GAIN_W-1:0]         quo_reg;
    logic [skf_pkg::DIV_CNT_W-1:0]      cnt_reg;
    logic                               done_reg;
    logic [skf_pkg::DEN_W+1:0]          trial;
    logic                               ge;

    // Trial subtraction of the divisor from the partial remainder
    assign trial = {1'b0, rem_reg} - {2'b00, divisor};
    assign ge    = ~trial[skf_pkg::DEN_W+1];

    // Control counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= skf_pkg::DIV_CNT_W'(skf_pkg::DIV_STEPS);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            done_reg <= (cnt_reg == skf_pkg::DIV_CNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Remainder and quotient shift registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {2'b00, dividend};
            quo_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            // remainder stays below the divisor, so the top bit is free for the shift
            if (ge)
                rem_reg <= {trial[skf_pkg::DEN_W-1:0], 1'b0};
            else
                rem_reg <= {rem_reg[skf_pkg::DEN_W-1:0], 1'b0};
            quo_reg <= {quo_reg[skf_pkg::GAIN_W-2:0], ge};
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// File: src/skf_datapath.sv
// Datapath of the scalar Kalman filter: config registers, state, arithmetic stages.
// Depends on skf_pkg and skf_div; driven by commands from skf_ctrl.
module skf_datapath (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_wr_en,
    input  logic [skf_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [skf_pkg::CFG_W-1:0]               cfg_data,
    input  logic signed [skf_pkg::MEAS_W-1:0]       measurement,
    output logic signed [skf_pkg::EST_W-1:0]        estimate,
    input  skf_pkg::skf_cmd_t                       cmd,
    output skf_pkg::skf_status_t                    status
);

    // Configuration registers and filter state
    logic [skf_pkg::CFG_W-1:0]              init_cov_reg;
    logic [skf_pkg::CFG_W-1:0]              q_reg;
    logic [skf_pkg::CFG_W-1:0]              r_reg;
    logic signed [skf_pkg::EST_W-1:0]       est_reg;
    logic [skf_pkg::COV_W-1:0]              cov_reg;

    // Working registers
    logic signed [skf_pkg::MEAS_W-1:0]      meas_reg;
    logic [skf_pkg::COV_W-1:0]              pp_reg;
    logic signed [skf_pkg::DIFF_W-1:0]      diff_reg;
    logic [skf_pkg::DEN_W-1:0]              den_reg;
    logic signed [skf_pkg::PROD_W-1:0]      prod_reg;
    logic [skf_pkg::CPROD_W-1:0]            cprod_reg;
    logic signed [skf_pkg::EST_W-1:0]       out_reg;

    // Combinational terms
    logic [skf_pkg::COV_W:0]                pp_sum;
    logic [skf_pkg::COV_W-1:0]              pp_sat;
    logic signed [skf_pkg::DIFF_W-1:0]      diff_next;
    logic [skf_pkg::GAIN_W-1:0]             quotient;
    logic                                   div_done;
    logic [skf_pkg::GAIN_W-1:0]             gain;
    logic signed [skf_pkg::GAIN_W:0]        gain_s;
    logic [skf_pkg::GAIN_W-1:0]             one_minus_gain;
    logic signed [skf_pkg::PROD_W-1:0]      prod_next;
    logic [skf_pkg::CPROD_W-1:0]            cprod_next;
    logic signed [skf_pkg::PROD_W-skf_pkg::FRAC_W-1:0] corr;
    logic signed [skf_pkg::PROD_W-skf_pkg::FRAC_W:0]   est_sum;
    logic signed [skf_pkg::EST_W-1:0]       est_next;
    logic [skf_pkg::CFG_W-1:0]              init_cov_next;

    // Predicted covariance with saturation, and innovation
    assign pp_sum    = {1'b0, cov_reg} + {1'b0, q_reg};
    assign pp_sat    = pp_sum[skf_pkg::COV_W] ? '1 : pp_sum[skf_pkg::COV_W-1:0];
    assign diff_next = $signed({meas_reg[skf_pkg::MEAS_W-1], meas_reg, {skf_pkg::FRAC_W{1'b0}}})
                     - $signed({est_reg[skf_pkg::EST_W-1], est_reg});

    skf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (pp_reg),
        .divisor  (den_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    // Gain: 1.0 on a zero denominator, clamped to 1.0 otherwise
    always_comb
    begin
        if (den_reg == '0)
            gain = skf_pkg::GAIN_ONE;
        else if (quotient > skf_pkg::GAIN_ONE)
            gain = skf_pkg::GAIN_ONE;
        else
            gain = quotient;
    end

    assign gain_s         = $signed({1'b0, gain});
    assign one_minus_gain = skf_pkg::GAIN_ONE - gain;
    assign prod_next      = diff_reg * gain_s;
    assign cprod_next     = one_minus_gain * pp_reg;

    // Floor shift of the correction, then add with clamp to 32-bit signed
    assign corr    = prod_reg[skf_pkg::PROD_W-1:skf_pkg::FRAC_W];
    assign est_sum = $signed({{(skf_pkg::PROD_W-skf_pkg::FRAC_W-skf_pkg::EST_W+1)
                                {est_reg[skf_pkg::EST_W-1]}}, est_reg})
                   + $signed({corr[skf_pkg::PROD_W-skf_pkg::FRAC_W-1], corr});

    always_comb
    begin
        if (est_sum > $signed({{(skf_pkg::PROD_W-skf_pkg::FRAC_W-skf_pkg::EST_W+1){1'b0}},
                               1'b0, {(skf_pkg::EST_W-1){1'b1}}}))
            est_next = {1'b0, {(skf_pkg::EST_W-1){1'b1}}};
        else if (est_sum < $signed({{(skf_pkg::PROD_W-skf_pkg::FRAC_W-skf_pkg::EST_W+1){1'b1}},
                                    1'b1, {(skf_pkg::EST_W-1){1'b0}}}))
            est_next = {1'b1, {(skf_pkg::EST_W-1){1'b0}}};
        else
            est_next = est_sum[skf_pkg::EST_W-1:0];
    end

    // Initial covariance as seen by a restart in the same cycle as its write
    always_comb
    begin
        init_cov_next = init_cov_reg;
        if (cfg_wr_en && (cfg_index == skf_pkg::REG_INIT_COV))
            init_cov_next = cfg_data;
    end

    // Configuration registers and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_cov_reg <= skf_pkg::INIT_COV_RST;
            q_reg        <= skf_pkg::PROC_NOISE_RST;
            r_reg        <= skf_pkg::MEAS_NOISE_RST;
            est_reg      <= '0;
            cov_reg      <= skf_pkg::INIT_COV_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                skf_pkg::REG_INIT_COV,
                skf_pkg::REG_PROC_NOISE,
                skf_pkg::REG_MEAS_NOISE:
                begin
                    est_reg <= '0;
                    cov_reg <= init_cov_next;
                end
                default:
                begin
                end
            endcase
            case (cfg_index)
                skf_pkg::REG_INIT_COV:   init_cov_reg <= cfg_data;
                skf_pkg::REG_PROC_NOISE: q_reg        <= cfg_data;
                skf_pkg::REG_MEAS_NOISE: r_reg        <= cfg_data;
                default:
                begin
                end
            endcase
        end
        else if (cmd.update)
        begin
            est_reg <= est_next;
            cov_reg <= cprod_reg[skf_pkg::FRAC_W+skf_pkg::COV_W-1:skf_pkg::FRAC_W];
        end
    end

    // Working registers, loaded stage by stage
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
            meas_reg <= measurement;
        if (cmd.prep)
        begin
            pp_reg   <= pp_sat;
            diff_reg <= diff_next;
        end
        if (cmd.denom)
            den_reg <= {1'b0, pp_reg} + {1'b0, r_reg};
        if (cmd.mult)
        begin
            prod_reg  <= prod_next;
            cprod_reg <= cprod_next;
        end
        if (cmd.push)
            out_reg <= est_reg;
    end

    assign estimate        = out_reg;
    assign status.div_done = div_done;

endmodule

// File: src/skf_ctrl.sv
// Controller of the scalar Kalman filter: sequences one word through the datapath
// and owns both handshakes. Depends on skf_pkg.
module skf_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  logic                    out_ready,
    output skf_pkg::skf_cmd_t       cmd,
    input  skf_pkg::skf_status_t    status
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DENOM,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_MULT,
        ST_UPDATE,
        ST_PUSH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_DENOM;
            end
            ST_DENOM:
            begin
                cmd.denom  = 1'b1;
                state_next = ST_DIV_START;
            end
            ST_DIV_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (status.div_done)
                    state_next = ST_MULT;
            end
            ST_MULT:
            begin
                cmd.mult   = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                // wait here while the previous word is still unread
                if (out_free)
                begin
                    cmd.push       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // A pushed word shows up as valid on the next cycle
    a_push_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |=> out_valid)
        else $error("pushed word not presented");

    // Only one word in flight: no acceptance right after an acceptance
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second word accepted while busy");

    // Divider completion only seen while waiting for it
    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> (state_reg == ST_DIV_WAIT))
        else $error("divider done outside wait state");

    // Divider start is followed by the wait state
    a_div_seq: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> (state_reg == ST_DIV_WAIT) && !status.div_done)
        else $error("divider sequencing broken");

endmodule

// File: src/scalar_kalman_filter.sv
// Scalar (one-dimensional) Kalman filter over a stream of signed 16-bit samples.
// Input word: measurement, signed integer, on a valid/ready channel (in_valid, in_ready).
// Output word: estimate, signed Q16.16, on a valid/ready channel (out_valid, out_ready).
// Config port: cfg_wr_en, cfg_index, cfg_data. Index 0 initial covariance, 1 process
// noise, 2 measurement noise (unsigned Q16.16). Any valid write restarts the filter:
// estimate to 0, covariance to the initial covariance. Write only while idle.
// Sequence: after acceptance the controller runs prep, denominator, divider start, divider
// wait, multiply, update and push; in_ready returns with out_valid, one word in flight.
// The gain division, one quotient bit per cycle in the iterative divider, is most of it.
// Stall: the result sits in an output register; if it is still unread when the next
// result is ready, the controller holds that result until out_ready, and in_ready
// stays low meanwhile.
// Reset (rst_n, async, active low): registers return to 1.0, 0.01 and 1.0, the
// estimate to 0, the covariance to 1.0; no word is pending.
// Depends on skf_pkg, skf_ctrl, skf_datapath, skf_div.
module scalar_kalman_filter (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [skf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [skf_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [skf_pkg::MEAS_W-1:0]   measurement,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [skf_pkg::EST_W-1:0]    estimate
);

    skf_pkg::skf_cmd_t      cmd;
    skf_pkg::skf_status_t   status;

    skf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    skf_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .measurement (measurement),
        .estimate    (estimate),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

// File: tb/sv/skf_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the scalar Kalman filter: snoops config writes and both streams,
// predicts each estimate in fixed point and compares results in order. Depends on skf_pkg.
module skf_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [skf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [skf_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic signed [skf_pkg::MEAS_W-1:0]   measurement,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic signed [skf_pkg::EST_W-1:0]    estimate,
    output int                                  fail_count,
    output int                                  pending_count
);

    localparam longint EST_MAX = (64'sd1 <<< (skf_pkg::EST_W - 1)) - 1;
    localparam longint EST_MIN = -(64'sd1 <<< (skf_pkg::EST_W - 1));
    localparam longint COV_MAX = (64'sd1 <<< skf_pkg::COV_W) - 1;

    // Shadow copy of the registers and filter state
    logic [skf_pkg::CFG_W-1:0]        init_cov;
    logic [skf_pkg::CFG_W-1:0]        proc_noise;
    logic [skf_pkg::CFG_W-1:0]        meas_noise;
    logic signed [skf_pkg::EST_W-1:0] est_state;
    logic [skf_pkg::COV_W-1:0]        cov_state;

    logic signed [skf_pkg::EST_W-1:0] est_q[$];
    int                               errors;

    // One filter update: predict covariance, form the gain, correct the estimate
    function automatic logic signed [skf_pkg::EST_W-1:0] kalman_update(
        input logic signed [skf_pkg::MEAS_W-1:0] meas
    );
        longint pred_cov;
        longint denom;
        longint gain;
        longint diff;
        longint next_est;
        pred_cov = longint'(cov_state) + longint'(proc_noise);
        if (pred_cov > COV_MAX)
            pred_cov = COV_MAX;
        denom = pred_cov + longint'(meas_noise);
        if (denom == 0)
            gain = longint'(skf_pkg::GAIN_ONE);
        else
        begin
            gain = (pred_cov <<< skf_pkg::FRAC_W) / denom;
            if (gain > longint'(skf_pkg::GAIN_ONE))
                gain = longint'(skf_pkg::GAIN_ONE);
        end
        // floor of the scaled product: arithmetic shift rounds toward minus infinity
        diff     = (longint'(meas) <<< skf_pkg::FRAC_W) - longint'(est_state);
        next_est = longint'(est_state) + ((diff * gain) >>> skf_pkg::FRAC_W);
        if (next_est > EST_MAX)
            next_est = EST_MAX;
        if (next_est < EST_MIN)
            next_est = EST_MIN;
        est_state = skf_pkg::EST_W'(next_est);
        cov_state = skf_pkg::COV_W'(((longint'(skf_pkg::GAIN_ONE) - gain) * pred_cov)
                                    >>> skf_pkg::FRAC_W);
        return est_state;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        logic signed [skf_pkg::EST_W-1:0] want;
        logic                             reg_hit;
        if (!rst_n)
        begin
            init_cov      = skf_pkg::INIT_COV_RST;
            proc_noise    = skf_pkg::PROC_NOISE_RST;
            meas_noise    = skf_pkg::MEAS_NOISE_RST;
            est_state     = '0;
            cov_state     = skf_pkg::INIT_COV_RST;
            est_q.delete();
            errors        = 0;
            fail_count    <= 0;
            pending_count <= 0;
        end
        else
        begin
            // Register write: a known index restarts the filter, others are dropped
            if (cfg_wr_en)
            begin
                reg_hit = 1'b1;
                case (cfg_index)
                    skf_pkg::REG_INIT_COV:   init_cov   = cfg_data;
                    skf_pkg::REG_PROC_NOISE: proc_noise = cfg_data;
                    skf_pkg::REG_MEAS_NOISE: meas_noise = cfg_data;
                    default:                 reg_hit    = 1'b0;
                endcase
                if (reg_hit)
                begin
                    est_state = '0;
                    cov_state = init_cov;
                end
            end

            if (in_valid && in_ready)
                est_q.push_back(kalman_update(measurement));

            // Output word: compare against the oldest prediction
            if (out_valid && out_ready)
            begin
                if (est_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected estimate word: expected none, got %0d",
                             $time, estimate);
                end
                else
                begin
                    want = est_q.pop_front();
                    if (want !== estimate)
                    begin
                        errors++;
                        $display("%0t: estimate mismatch: expected %0d, got %0d",
                                 $time, want, estimate);
                    end
                end
            end

            fail_count    <= errors;
            pending_count <= est_q.size();
        end
    end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// Top of the scalar Kalman filter testbench: clock, reset, config writes, measurement
// stimulus and output back-pressure. Depends on skf_pkg, scalar_kalman_filter, skf_checker.
module tb;

    localparam int CLK_PERIOD  = 10;
    localparam int LIMIT       = 1_500_000;
    localparam int SETTLE      = 30;       // a bit more than the filter latency
    localparam int PHASES      = 6;
    localparam int PHASE_WORDS = 300;
    localparam int HOLD_AT     = 450;      // input count that triggers the long stall
    localparam int HOLD_LEN    = 400;

    // Index with no register behind it
    localparam logic [skf_pkg::CFG_IDX_W-1:0] REG_NONE = 2'd3;

    logic                              clk;
    logic                              rst_n;
    logic                              cfg_wr_en;
    logic [skf_pkg::CFG_IDX_W-1:0]     cfg_index;
    logic [skf_pkg::CFG_W-1:0]         cfg_data;
    logic                              in_valid;
    logic                              in_ready;
    logic signed [skf_pkg::MEAS_W-1:0] measurement;
    logic                              out_valid;
    logic                              out_ready;
    logic signed [skf_pkg::EST_W-1:0]  estimate;
    int                                fail_count;
    int                                pending_count;
    int                                in_words;
    logic signed [skf_pkg::MEAS_W-1:0] level;

    scalar_kalman_filter u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .measurement (measurement),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .estimate    (estimate)
    );

    skf_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .measurement   (measurement),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .estimate      (estimate),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_words <= 0;
        else if (in_valid && in_ready)
            in_words <= in_words + 1;
    end

    // Hold valid and the word until the filter takes it
    task automatic send_word(input logic signed [skf_pkg::MEAS_W-1:0] m);
        in_valid    <= 1'b1;
        measurement <= m;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic pause_input(input int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Send one word, then idle for a mostly short random gap
    task automatic feed(input logic signed [skf_pkg::MEAS_W-1:0] m);
        int r;
        send_word(m);
        r = $urandom_range(0, 99);
        if (r < 50)
            pause_input(0);
        else if (r < 85)
            pause_input($urandom_range(1, 3));
        else if (r < 97)
            pause_input($urandom_range(4, 15));
        else
            pause_input($urandom_range(30, 100));
    endtask

    // Wait until every word in flight has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [skf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [skf_pkg::CFG_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_filter(input logic [skf_pkg::CFG_W-1:0] p0,
                              input logic [skf_pkg::CFG_W-1:0] q,
                              input logic [skf_pkg::CFG_W-1:0] r);
        drain();
        write_reg(skf_pkg::REG_INIT_COV, p0);
        write_reg(skf_pkg::REG_PROC_NOISE, q);
        write_reg(skf_pkg::REG_MEAS_NOISE, r);
    endtask

    // Covariance/noise values: extremes, small and full range
    function automatic logic [skf_pkg::CFG_W-1:0] pick_cov();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return $urandom();
            3:       return $urandom_range(0, 32'h0001_0000);
            4:       return $urandom_range(1, 32'h0010_0000);
            default: return $urandom_range(32'h0000_4000, 32'h0004_0000);
        endcase
    endfunction

    // Sensor-like samples: a drifting level with noise, plus raw and extreme values
    function automatic logic signed [skf_pkg::MEAS_W-1:0] pick_meas();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            level = skf_pkg::MEAS_W'($urandom());
        if (r < 40)
            return level + skf_pkg::MEAS_W'($urandom_range(0, 512)) - skf_pkg::MEAS_W'(256);
        else if (r < 80)
            return skf_pkg::MEAS_W'($urandom());
        else if (r < 90)
        begin
            case ($urandom_range(0, 3))
                0:       return 16'sh7FFF;
                1:       return 16'sh8000;
                2:       return '0;
                default: return -16'sd1;
            endcase
        end
        else
            return level;
    endfunction

    // Receiver: random stalls, ready runs, and one long hold-off
    initial
    begin : receiver
        int  r;
        bit  held;
        held      = 1'b0;
        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            r = $urandom_range(0, 99);
            if (!held && in_words >= HOLD_AT)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge clk);
            end
            else if (r < 60)
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge clk);
            end
            else if (r < 95)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(20, 80)) @(posedge clk);
            end
        end
    end

    // Run limit
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Stimulus and verdict
    initial
    begin
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_index   <= skf_pkg::REG_INIT_COV;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        measurement <= '0;
        level       = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings, full-scale steps back to back
        send_word(16'sh7FFF);
        send_word(16'sh7FFF);
        send_word(16'sh8000);
        send_word(16'sh8000);
        send_word(-16'sd1);
        send_word(16'sd1);
        feed(16'sd0);
        feed(16'sh7FFF);

        // Write to an unused index: state must carry on
        drain();
        write_reg(REG_NONE, '1);
        feed(16'sh8000);
        feed(16'sd100);

        // Zero denominator: gain is one
        set_filter('0, '0, '0);
        feed(16'sh7FFF);
        feed(16'sh8000);
        feed(16'sd12345);

        // Predicted covariance saturates, widest denominator
        set_filter('1, '1, '1);
        feed(16'sh8000);
        feed(16'sh7FFF);
        feed(16'sd0);
        feed(16'sh7FFF);

        // No measurement noise, then huge measurement noise, then tiny values
        set_filter(32'h0001_0000, '0, '0);
        feed(16'sd5000);
        feed(-16'sd5000);
        set_filter('0, '0, '1);
        feed(16'sh7FFF);
        feed(16'sh8000);
        set_filter(32'd1, 32'd1, 32'd1);
        feed(16'sh7FFF);
        feed(-16'sd7);

        // Random phases, each with its own filter settings
        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph == 0)
                set_filter(skf_pkg::INIT_COV_RST, skf_pkg::PROC_NOISE_RST,
                           skf_pkg::MEAS_NOISE_RST);
            else
                set_filter(pick_cov(), pick_cov(), pick_cov());
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_NONE, $urandom());
            level = skf_pkg::MEAS_W'($urandom());
            for (int i = 0; i < PHASE_WORDS; i++)
                feed(pick_meas());
        end

        drain();
        if (fail_count == 0 && pending_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: filelist.f
src/skf_pkg.sv
src/skf_div.sv
src/skf_datapath.sv
src/skf_ctrl.sv
src/scalar_kalman_filter.sv
tb/sv/skf_checker.sv
tb/sv/tb.sv
